// File: src/pmt_pkg.sv
package pmt_pkg;

  // parse phases of the section walker
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_LEN   = 3'd1,
    PH_HDR   = 3'd2,
    PH_SKIP  = 3'd3,
    PH_ENTRY = 3'd4,
    PH_CRC   = 3'd5
  } phase_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_HDR   = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERR   = 2'd3
  } kind_e;

  localparam int unsigned HdrBytes   = 9;
  localparam int unsigned EntryBytes = 5;
  localparam int unsigned CrcBytes   = 4;
  localparam int unsigned MinSection = 13;

  // one result request
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  table_code;
    logic [15:0] prog_num;
    logic [4:0]  version;
    logic        current_flag;
    logic [7:0]  section_index;
    logic [7:0]  last_section_index;
    logic [12:0] clock_ref_pid;
    logic [11:0] desc_length;
    logic [7:0]  stream_kind;
    logic [12:0] es_pid;
    logic [31:0] crc_word;
  } result_t;

endpackage

// File: src/pmt_front.sv
module pmt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [7:0]        data_byte_i,
  input  logic              section_start_i,
  output logic              res_valid_o,
  output pmt_pkg::result_t  res_o
);

  pmt_pkg::phase_e phase_q, phase_d;
  logic [11:0] cnt_q, cnt_d;
  logic [11:0] size_q, size_d;
  logic [11:0] skip_q, skip_d;
  logic [11:0] loop_q, loop_d;
  logic [31:0] shift_q, shift_d;
  logic [39:0] hdr_q, hdr_d;
  logic [12:0] pcr_q, pcr_d;
  logic [7:0]  stype_q, stype_d;
  logic [7:0]  tid_q, tid_d;

  logic [31:0] sh_new;
  logic [11:0] cnt_inc;
  logic [12:0] ent_need;
  logic [11:0] room;

  assign sh_new   = {shift_q[23:0], data_byte_i};
  assign cnt_inc  = cnt_q + 12'd1;
  assign ent_need = 13'(pmt_pkg::EntryBytes) + {1'b0, sh_new[11:0]};
  assign room     = size_q - 12'(pmt_pkg::MinSection);

  // next state of the walker
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    size_d  = size_q;
    skip_d  = skip_q;
    loop_d  = loop_q;
    shift_d = shift_q;
    hdr_d   = hdr_q;
    pcr_d   = pcr_q;
    stype_d = stype_q;
    tid_d   = tid_q;
    if (valid_i && section_start_i) begin
      tid_d   = data_byte_i;
      phase_d = pmt_pkg::PH_LEN;
      cnt_d   = '0;
      shift_d = '0;
      skip_d  = '0;
      loop_d  = '0;
      size_d  = '0;
    end else if (valid_i) begin
      case (phase_q)
        pmt_pkg::PH_LEN: begin
          shift_d = {16'd0, sh_new[15:0]};
          cnt_d   = cnt_inc;
          if (cnt_inc == 12'd2) begin
            size_d  = sh_new[11:0];
            cnt_d   = '0;
            shift_d = '0;
            phase_d = (sh_new[11:0] < 12'(pmt_pkg::MinSection)) ?
                      pmt_pkg::PH_IDLE : pmt_pkg::PH_HDR;
          end
        end
        pmt_pkg::PH_HDR: begin
          if (cnt_q < 12'd5) hdr_d = {hdr_q[31:0], data_byte_i};
          else shift_d = sh_new;
          cnt_d = cnt_inc;
          if (cnt_inc == 12'(pmt_pkg::HdrBytes)) begin
            pcr_d  = sh_new[28:16];
            loop_d = room - sh_new[11:0];
            skip_d = sh_new[11:0];
            if (sh_new[11:0] > room) phase_d = pmt_pkg::PH_IDLE;
            else if (sh_new[11:0] != 12'd0) phase_d = pmt_pkg::PH_SKIP;
            else begin
              cnt_d   = '0;
              shift_d = '0;
              phase_d = (room != sh_new[11:0]) ? pmt_pkg::PH_ENTRY : pmt_pkg::PH_CRC;
            end
          end
        end
        pmt_pkg::PH_SKIP: begin
          skip_d = skip_q - 12'd1;
          if (skip_q <= 12'd1) begin
            skip_d  = '0;
            cnt_d   = '0;
            shift_d = '0;
            phase_d = (loop_q != 12'd0) ? pmt_pkg::PH_ENTRY : pmt_pkg::PH_CRC;
          end
        end
        pmt_pkg::PH_ENTRY: begin
          if (cnt_q == 12'd0) stype_d = data_byte_i;
          else shift_d = sh_new;
          cnt_d = cnt_inc;
          if (cnt_inc == 12'(pmt_pkg::EntryBytes)) begin
            loop_d = loop_q - ent_need[11:0];
            skip_d = sh_new[11:0];
            if (ent_need > {1'b0, loop_q}) phase_d = pmt_pkg::PH_IDLE;
            else if (sh_new[11:0] != 12'd0) phase_d = pmt_pkg::PH_SKIP;
            else begin
              cnt_d   = '0;
              shift_d = '0;
              phase_d = (loop_q != ent_need[11:0]) ?
                        pmt_pkg::PH_ENTRY : pmt_pkg::PH_CRC;
            end
          end
        end
        pmt_pkg::PH_CRC: begin
          shift_d = sh_new;
          cnt_d   = cnt_inc;
          if (cnt_inc == 12'(pmt_pkg::CrcBytes)) phase_d = pmt_pkg::PH_IDLE;
        end
        default: ;
      endcase
    end
  end

  // result request for this byte
  always_comb begin
    res_valid_o            = 1'b0;
    res_o                  = '0;
    res_o.table_code       = tid_q;
    res_o.prog_num         = hdr_q[39:24];
    res_o.version          = hdr_q[21:17];
    res_o.current_flag     = hdr_q[16];
    res_o.section_index    = hdr_q[15:8];
    res_o.last_section_index = hdr_q[7:0];
    res_o.clock_ref_pid    = pcr_q;
    if (valid_i && !section_start_i) begin
      case (phase_q)
        pmt_pkg::PH_LEN: begin
          if (cnt_inc == 12'd2 && sh_new[11:0] < 12'(pmt_pkg::MinSection)) begin
            res_valid_o = 1'b1;
          end
        end
        pmt_pkg::PH_HDR: begin
          if (cnt_inc == 12'(pmt_pkg::HdrBytes)) begin
            res_valid_o             = 1'b1;
            res_o.prog_num          = hdr_q[39:24];
            res_o.clock_ref_pid     = sh_new[28:16];
            res_o.desc_length       = sh_new[11:0];
            if (sh_new[11:0] > room) res_valid_o = 1'b1;
          end
        end
        pmt_pkg::PH_ENTRY: begin
          if (cnt_inc == 12'(pmt_pkg::EntryBytes)) begin
            res_valid_o       = 1'b1;
            res_o.kind        = pmt_pkg::KIND_ENTRY;
            res_o.desc_length = sh_new[11:0];
            res_o.stream_kind = stype_q;
            res_o.es_pid      = sh_new[28:16];
          end
        end
        pmt_pkg::PH_CRC: begin
          if (cnt_inc == 12'(pmt_pkg::CrcBytes)) begin
            res_valid_o    = 1'b1;
            res_o.kind     = pmt_pkg::KIND_END;
            res_o.crc_word = sh_new;
          end
        end
        default: ;
      endcase
    end
    // malformed sections carry only the table id
    if (res_valid_o && ((phase_q == pmt_pkg::PH_LEN) ||
        (phase_q == pmt_pkg::PH_HDR && sh_new[11:0] > room) ||
        (phase_q == pmt_pkg::PH_ENTRY && ent_need > {1'b0, loop_q}))) begin
      res_o            = '0;
      res_o.kind       = pmt_pkg::KIND_ERR;
      res_o.table_code = tid_q;
    end
  end

  // walker registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pmt_pkg::PH_IDLE;
      cnt_q   <= '0;
      size_q  <= '0;
      skip_q  <= '0;
      loop_q  <= '0;
      shift_q <= '0;
      hdr_q   <= '0;
      pcr_q   <= '0;
      stype_q <= '0;
      tid_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      size_q  <= size_d;
      skip_q  <= skip_d;
      loop_q  <= loop_d;
      shift_q <= shift_d;
      hdr_q   <= hdr_d;
      pcr_q   <= pcr_d;
      stype_q <= stype_d;
      tid_q   <= tid_d;
    end
  end

  // the section length is legal throughout the header phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == pmt_pkg::PH_HDR) |-> (size_q >= 12'(pmt_pkg::MinSection)))
    else $error("header phase with short section");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == pmt_pkg::PH_SKIP) |-> (skip_q != 12'd0))
    else $error("skip phase with nothing to skip");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == pmt_pkg::PH_ENTRY) |-> (cnt_q < 12'(pmt_pkg::EntryBytes)))
    else $error("entry byte count overran");

endmodule

// File: src/pmt_queue.sv
module pmt_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pmt_pkg::result_t  push_data_i,
  output logic              almost_full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output pmt_pkg::result_t  data_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  pmt_pkg::result_t mem_q [Depth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Aw:0]   cnt_q;

  assign valid_o       = (cnt_q != '0);
  assign data_o        = mem_q[rp_q];
  // one slot spare so the front never has to be stopped mid-byte
  assign almost_full_o = (cnt_q >= (Aw+1)'(Depth - 1));

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + Aw'(1);
      if (pop_i)  rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + Aw'(1);
      cnt_q <= cnt_q + (Aw+1)'(push_i) - (Aw+1)'(pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && cnt_q == (Aw+1)'(Depth) && !pop_i))
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue underflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (Aw+1)'(Depth))
    else $error("queue count out of range");

endmodule

// File: src/pmt_section_parser.sv
// channel | valid           | stall            | payload
// in      | valid_i         | stall_o          | data_byte_i, section_start_i
// out     | valid_o         | stall_i          | kind_o .. crc_word_o
//
// One byte per cycle while stall_o is low, bytes back to back; a result is
// written into the result queue with its last byte and leaves from there.
// Reset clears the parse phase and the result queue.
// The input stalls only when the result queue is near full, so the
// output side can stall freely without losing results.
module pmt_section_parser #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        section_start_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  table_code_o,
  output logic [15:0] prog_num_o,
  output logic [4:0]  version_o,
  output logic        current_flag_o,
  output logic [7:0]  section_index_o,
  output logic [7:0]  last_section_index_o,
  output logic [12:0] clock_ref_pid_o,
  output logic [11:0] desc_length_o,
  output logic [7:0]  stream_kind_o,
  output logic [12:0] es_pid_o,
  output logic [31:0] crc_word_o
);

  logic             acc;
  logic             res_valid;
  logic             afull;
  pmt_pkg::result_t res, qout;

  assign stall_o = afull;
  assign acc     = valid_i && !afull;

  // front: byte walker
  pmt_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (acc),
    .data_byte_i     (data_byte_i),
    .section_start_i (section_start_i),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  // back: result queue to the output
  pmt_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (res_valid),
    .push_data_i   (res),
    .almost_full_o (afull),
    .valid_o       (valid_o),
    .pop_i         (valid_o && !stall_i),
    .data_o        (qout)
  );

  assign kind_o               = qout.kind;
  assign table_code_o         = qout.table_code;
  assign prog_num_o           = qout.prog_num;
  assign version_o            = qout.version;
  assign current_flag_o       = qout.current_flag;
  assign section_index_o      = qout.section_index;
  assign last_section_index_o = qout.last_section_index;
  assign clock_ref_pid_o      = qout.clock_ref_pid;
  assign desc_length_o        = qout.desc_length;
  assign stream_kind_o        = qout.stream_kind;
  assign es_pid_o             = qout.es_pid;
  assign crc_word_o           = qout.crc_word;

endmodule

// File: sim/tb_pmt_section_parser.sv
`timescale 1ns / 1ps

module tb_pmt_section_parser;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned NumBytes   = 900;

  // one byte request with an optional typed kind for the directed rows
  typedef struct {
    logic [7:0]     data;
    logic           start;
    bit             has_kind;
    pmt_pkg::kind_e kind;
  } byte_req_t;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  logic [7:0]  data_byte_i;
  logic        section_start_i;
  logic        valid_o;
  logic        stall_i;
  logic [1:0]  kind_o;
  logic [7:0]  table_code_o;
  logic [15:0] prog_num_o;
  logic [4:0]  version_o;
  logic        current_flag_o;
  logic [7:0]  section_index_o;
  logic [7:0]  last_section_index_o;
  logic [12:0] clock_ref_pid_o;
  logic [11:0] desc_length_o;
  logic [7:0]  stream_kind_o;
  logic [12:0] es_pid_o;
  logic [31:0] crc_word_o;

  pmt_section_parser uut (.*);

  byte_req_t         byte_q[$];
  pmt_pkg::result_t  pending_results[$];
  int         errors;
  int         kind_count[4];
  int         bytes_sent;
  int         idle_cycles;
  bit         hold_req;
  bit         drain_req;
  bit         stim_done;

  // parser mirror state
  pmt_pkg::phase_e ph;
  logic [11:0] cnt;
  logic [11:0] sec_size;
  logic [11:0] skip_n;
  logic [11:0] loop_n;
  logic [31:0] shift;
  logic [58:0] hdr;
  logic [7:0]  etype;
  logic [7:0]  tid;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic pmt_pkg::result_t header_result(pmt_pkg::kind_e k);
    pmt_pkg::result_t r;
    r = '0;
    r.kind = k;
    r.table_code = tid;
    r.prog_num = hdr[52:37];
    r.version = hdr[34:30];
    r.current_flag = hdr[29];
    r.section_index = hdr[28:21];
    r.last_section_index = hdr[20:13];
    r.clock_ref_pid = hdr[12:0];
    return r;
  endfunction

  // after a skipped descriptor block: next entry or the crc
  function automatic void after_skip();
    cnt = '0;
    shift = '0;
    ph = (loop_n > 0) ? pmt_pkg::PH_ENTRY : pmt_pkg::PH_CRC;
  endfunction

  // advance the mirror by one byte, returns 1 when a result is due
  function automatic bit parse_byte(input logic [7:0] b, input logic st,
                                    output pmt_pkg::result_t r);
    logic [11:0] len12;
    logic [12:0] need;
    r = '0;
    if (st) begin
      tid = b;
      ph = pmt_pkg::PH_LEN;
      cnt = '0;
      shift = '0;
      hdr = '0;
      etype = '0;
      skip_n = '0;
      loop_n = '0;
      sec_size = '0;
      return 1'b0;
    end
    case (ph)
      pmt_pkg::PH_LEN: begin
        shift = {16'h0, shift[7:0], b};
        cnt++;
        if (cnt < 2) return 1'b0;
        sec_size = shift[11:0];
        if (sec_size < pmt_pkg::MinSection) begin
          r.kind = pmt_pkg::KIND_ERR;
          r.table_code = tid;
          ph = pmt_pkg::PH_IDLE;
          return 1'b1;
        end
        ph = pmt_pkg::PH_HDR;
        cnt = '0;
        shift = '0;
        hdr = '0;
        return 1'b0;
      end
      pmt_pkg::PH_HDR: begin
        if (cnt < 5) hdr = {19'h0, hdr[31:0], b};
        else shift = {shift[23:0], b};
        cnt++;
        if (cnt < pmt_pkg::HdrBytes) return 1'b0;
        len12 = shift[11:0];
        hdr = {hdr[45:0], shift[28:16]};
        if (len12 > sec_size - pmt_pkg::MinSection) begin
          r = '0;
          r.kind = pmt_pkg::KIND_ERR;
          r.table_code = tid;
          ph = pmt_pkg::PH_IDLE;
          return 1'b1;
        end
        loop_n = 12'(sec_size - pmt_pkg::MinSection - len12);
        skip_n = len12;
        r = header_result(pmt_pkg::KIND_HDR);
        r.desc_length = len12;
        if (skip_n > 0) ph = pmt_pkg::PH_SKIP;
        else after_skip();
        return 1'b1;
      end
      pmt_pkg::PH_SKIP: begin
        if (skip_n > 0) skip_n--;
        if (skip_n == 0) after_skip();
        return 1'b0;
      end
      pmt_pkg::PH_ENTRY: begin
        if (cnt == 0) etype = b;
        else shift = {shift[23:0], b};
        cnt++;
        if (cnt < pmt_pkg::EntryBytes) return 1'b0;
        len12 = shift[11:0];
        need = 13'(pmt_pkg::EntryBytes) + {1'b0, len12};
        if (need > {1'b0, loop_n}) begin
          r.kind = pmt_pkg::KIND_ERR;
          r.table_code = tid;
          ph = pmt_pkg::PH_IDLE;
          return 1'b1;
        end
        loop_n = loop_n - need[11:0];
        skip_n = len12;
        r = header_result(pmt_pkg::KIND_ENTRY);
        r.desc_length = len12;
        r.stream_kind = etype;
        r.es_pid = shift[28:16];
        if (skip_n > 0) ph = pmt_pkg::PH_SKIP;
        else after_skip();
        return 1'b1;
      end
      pmt_pkg::PH_CRC: begin
        shift = {shift[23:0], b};
        cnt++;
        if (cnt < pmt_pkg::CrcBytes) return 1'b0;
        r = header_result(pmt_pkg::KIND_END);
        r.crc_word = shift;
        ph = pmt_pkg::PH_IDLE;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic add_row(logic [7:0] b, logic st, bit chk = 0,
                         pmt_pkg::kind_e k = pmt_pkg::KIND_HDR);
    byte_req_t q;
    q.data = b;
    q.start = st;
    q.has_kind = chk;
    q.kind = k;
    byte_q = {byte_q, q};
  endtask

  // one random section, mostly well formed, some broken
  task automatic gen_section();
    logic [7:0]  sec[$];
    int          n_ent;
    int          pil;
    int          pil_hdr;
    int          esl[4];
    int          esl_hdr[4];
    int          len;
    int          flaw;
    int          bad_ent;
    int          cut;
    n_ent = $urandom_range(0, 3);
    pil = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    pil_hdr = pil;
    len = 13 + pil;
    for (int i = 0; i < n_ent; i++) begin
      esl[i] = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      esl_hdr[i] = esl[i];
      len += 5 + esl[i];
    end
    flaw = $urandom_range(0, 11);
    if (flaw == 1) pil_hdr = pil + $urandom_range(1, 4095 - pil);
    if (flaw == 2 && n_ent > 0) begin
      bad_ent = $urandom_range(0, n_ent - 1);
      esl_hdr[bad_ent] = esl[bad_ent] + $urandom_range(1, 4000);
    end
    if (flaw == 0) len = $urandom_range(0, 12);
    // noise ahead of the section
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3)) add_row(8'($urandom_range(0, 255)), 1'b0);
    sec = {sec, 8'($urandom_range(0, 255))};
    sec = {sec, {4'($urandom_range(0, 15)), 4'(len >> 8)}};
    sec = {sec, 8'(len)};
    repeat (7) sec = {sec, 8'($urandom_range(0, 255))};
    sec = {sec, {4'($urandom_range(0, 15)), 4'(pil_hdr >> 8)}};
    sec = {sec, 8'(pil_hdr)};
    repeat (pil) sec = {sec, 8'($urandom_range(0, 255))};
    for (int i = 0; i < n_ent; i++) begin
      repeat (3) sec = {sec, 8'($urandom_range(0, 255))};
      sec = {sec, {4'($urandom_range(0, 15)), 4'(esl_hdr[i] >> 8)}};
      sec = {sec, 8'(esl_hdr[i])};
      repeat (esl[i]) sec = {sec, 8'($urandom_range(0, 255))};
    end
    repeat (4) sec = {sec, 8'($urandom_range(0, 255))};
    cut = sec.size();
    if (flaw == 3) cut = $urandom_range(1, sec.size() - 1);
    for (int i = 0; i < cut; i++) add_row(sec[i], i == 0);
  endtask

  // sender: bursts with gaps, one pause for a full drain
  initial begin
    byte_req_t         q;
    pmt_pkg::result_t  r;
    int          burst;
    bit          drained;
    rst_ni = 1'b0;
    valid_i = 1'b0;
    data_byte_i = '0;
    section_start_i = 1'b0;
    errors = 0;
    bytes_sent = 0;
    hold_req = 1'b0;
    drain_req = 1'b0;
    stim_done = 1'b0;
    drained = 1'b0;
    ph = pmt_pkg::PH_IDLE;
    cnt = '0;
    sec_size = '0;
    skip_n = '0;
    loop_n = '0;
    shift = '0;
    hdr = '0;
    etype = '0;
    tid = '0;
    // short section, zero length
    add_row(8'h00, 1'b1);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1, pmt_pkg::KIND_ERR);
    // stray bytes while idle
    add_row(8'hff, 1'b0);
    add_row(8'h5a, 1'b0);
    // smallest legal section with all-ones fields
    add_row(8'hff, 1'b1);
    add_row(8'hf0, 1'b0);
    add_row(8'h0d, 1'b0);
    repeat (7) add_row(8'hff, 1'b0);
    add_row(8'hf0, 1'b0);
    add_row(8'h00, 1'b0, 1, pmt_pkg::KIND_HDR);
    repeat (3) add_row(8'hff, 1'b0);
    add_row(8'hff, 1'b0, 1, pmt_pkg::KIND_END);
    // length twelve, one below the minimum
    add_row(8'h02, 1'b1);
    add_row(8'hb0, 1'b0);
    add_row(8'h0c, 1'b0, 1, pmt_pkg::KIND_ERR);
    while (byte_q.size() < NumBytes) gen_section();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst = $urandom_range(1, 40);
    while (byte_q.size() > 0) begin
      q = byte_q.pop_front();
      valid_i <= 1'b1;
      data_byte_i <= q.data;
      section_start_i <= q.start;
      do @(posedge clk_i); while (stall_o);
      bytes_sent++;
      if (parse_byte(q.data, q.start, r)) begin
        if (q.has_kind && r.kind != q.kind) begin
          $display("%0t: table row %0d kind expected %0d, model gives %0d",
                   $time, bytes_sent, q.kind, r.kind);
          errors++;
        end
        pending_results = {pending_results, r};
      end else if (q.has_kind) begin
        $display("%0t: table row %0d kind expected %0d, model gives none",
                 $time, bytes_sent, q.kind);
        errors++;
      end
      if (bytes_sent == 300) hold_req = 1'b1;
      burst--;
      if (bytes_sent == 600 && !drained) begin
        drained = 1'b1;
        valid_i <= 1'b0;
        while (pending_results.size() > 0) @(posedge clk_i);
      end else if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) begin
          valid_i <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk_i);
        end
      end
    end
    valid_i <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d section bytes: %0d headers, %0d entries, %0d ends, %0d errors",
             bytes_sent, kind_count[pmt_pkg::KIND_HDR], kind_count[pmt_pkg::KIND_ENTRY],
             kind_count[pmt_pkg::KIND_END], kind_count[pmt_pkg::KIND_ERR]);
    $display("covered short, overrun and cut sections, idle bytes and a long output stall");
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // receiver: stall pattern in phases, plus one long hold-off
  initial begin
    int mode;
    stall_i = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(16, 80)) begin
        if (hold_req) begin
          stall_i <= 1'b1;
          repeat (HoldCycles) @(posedge clk_i);
          hold_req = 1'b0;
        end
        case (mode)
          0: stall_i <= 1'b0;
          1: stall_i <= ($urandom_range(0, 3) == 0);
          default: stall_i <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h, got %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    pmt_pkg::result_t exp_r;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, kind %0d", $time, kind_o);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        kind_count[exp_r.kind]++;
        check_field("kind", 32'(exp_r.kind), 32'(kind_o));
        check_field("table_code", 32'(exp_r.table_code), 32'(table_code_o));
        check_field("prog_num", 32'(exp_r.prog_num), 32'(prog_num_o));
        check_field("version", 32'(exp_r.version), 32'(version_o));
        check_field("current_flag", 32'(exp_r.current_flag), 32'(current_flag_o));
        check_field("section_index", 32'(exp_r.section_index), 32'(section_index_o));
        check_field("last_section_index", 32'(exp_r.last_section_index),
                    32'(last_section_index_o));
        check_field("clock_ref_pid", 32'(exp_r.clock_ref_pid), 32'(clock_ref_pid_o));
        check_field("desc_length", 32'(exp_r.desc_length), 32'(desc_length_o));
        check_field("stream_kind", 32'(exp_r.stream_kind), 32'(stream_kind_o));
        check_field("es_pid", 32'(exp_r.es_pid), 32'(es_pid_o));
        check_field("crc_word", exp_r.crc_word, crc_word_o);
      end
    end
  end

  // watchdog on cycles without any request moving
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("%0t: timeout, %0d results still expected", $time,
               pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial idle_cycles = 0;
  initial kind_count = '{0, 0, 0, 0};

endmodule
